// ----- sv/spgt_pkg.sv -----
// package with command and register codes and the page clamp for the swipe page gesture tracker
package spgt_pkg;

    typedef enum logic [1:0] {
        CMD_PRESS   = 2'd0,
        CMD_MOVE    = 2'd1,
        CMD_RELEASE = 2'd2,
        CMD_SET     = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        REG_DRAG_THRESHOLD = 3'd0,
        REG_PAGE_THRESHOLD = 3'd1,
        REG_VERTICAL_MODE  = 3'd2,
        REG_PAGE_TOTAL     = 3'd3,
        REG_PAGE_SPAN      = 3'd4
    } reg_idx_t;

    localparam logic [15:0] DEF_DRAG_THRESHOLD = 16'd6;
    localparam logic [15:0] DEF_PAGE_THRESHOLD = 16'd48;
    localparam logic [15:0] DEF_PAGE_SPAN      = 16'd300;

    localparam int IN_DATA_W  = 56;
    localparam int OUT_DATA_W = 56;

    // clamp a signed page target into 0 .. total-1, or to 0 when total is 0
    function automatic logic [15:0] clamp_page(input logic signed [17:0] p,
                                               input logic [15:0] total);
        logic signed [17:0] tot_s;
        logic [15:0]        res;
        tot_s = $signed({2'b00, total});
        if (total == 16'd0 || p < 18'sd0) begin
            res = 16'd0;
        end
        else if (p >= tot_s) begin
            res = total - 16'd1;
        end
        else begin
            res = p[15:0];
        end
        return res;
    endfunction

endpackage

// ----- sv/swipe_page_gesture_tracker.sv -----
// swipe page gesture tracker: touch and page request items in, page and settle items out
//
// channel   dir  handshake                       item
// s_axis    in   s_axis_tvalid / s_axis_tready   command in tuser, touch and page request in tdata
// m_axis    out  m_axis_tvalid / m_axis_tready   page, drag offset and settle start in tdata
// apb       in   psel / penable / pready         five 16-bit or 1-bit registers at 4*i
//
// an item goes from accept to result through the input register, then the result register
// one item per cycle is sustained while the result is not stalled; state is updated as the
// item moves to the result register; a stalled result holds the result register and then
// the input register, which fill up in turn before s_axis_tready drops
// reset clears state, handshake valids and loads register defaults
module swipe_page_gesture_tracker (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // touch_x [15:0], touch_y [31:16], page_request [48:32], zero fill
    input  logic [spgt_pkg::IN_DATA_W-1:0]    s_axis_tdata,
    // command [1:0]
    input  logic [1:0]                        s_axis_tuser,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // current_page [15:0], page_changed [16], offset_now [33:17], drag_active [34],
    // settle_start [52:35], settle_valid [53], zero fill
    output logic [spgt_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [4:0]                        paddr,
    input  logic [31:0]                       pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready
);
    import spgt_pkg::*;

    // configuration
    logic [15:0] drag_threshold_reg;
    logic [15:0] page_threshold_reg;
    logic        vertical_mode_reg;
    logic [15:0] page_total_reg;
    logic [15:0] page_span_reg;

    // gesture state
    logic               pressed_reg, pressed_next;
    logic               dragging_reg, dragging_next;
    logic [15:0]        origin_x_reg, origin_x_next;
    logic [15:0]        origin_y_reg, origin_y_next;
    logic signed [16:0] drag_amount_reg, drag_amount_next;
    logic [15:0]        page_reg, page_next;

    // input stage
    logic               in_valid_reg;
    cmd_t               in_cmd_reg;
    logic [15:0]        in_x_reg;
    logic [15:0]        in_y_reg;
    logic signed [16:0] in_req_reg;

    // result stage
    logic                  out_valid_reg;
    logic [OUT_DATA_W-1:0] out_data_reg, out_data_next;

    logic               out_load;
    logic               proc;
    logic               in_take;
    logic               changed;
    logic               settle_ok;
    logic signed [17:0] settle;
    logic signed [16:0] dx, dy;
    logic [16:0]        abs_dx, abs_dy;
    logic signed [17:0] target;
    logic [15:0]        next_page;
    logic signed [17:0] m_ext, th_ext, span_ext;
    logic               cfg_wr;
    reg_idx_t           cfg_idx;

    assign pready   = 1'b1;
    assign cfg_idx  = reg_idx_t'(paddr[4:2]);
    assign cfg_wr   = psel && penable && pwrite && pready;

    always_comb
    begin
        case (cfg_idx)
            REG_DRAG_THRESHOLD: prdata = {16'd0, drag_threshold_reg};
            REG_PAGE_THRESHOLD: prdata = {16'd0, page_threshold_reg};
            REG_VERTICAL_MODE:  prdata = {31'd0, vertical_mode_reg};
            REG_PAGE_TOTAL:     prdata = {16'd0, page_total_reg};
            REG_PAGE_SPAN:      prdata = {16'd0, page_span_reg};
            default:            prdata = 32'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            drag_threshold_reg <= DEF_DRAG_THRESHOLD;
            page_threshold_reg <= DEF_PAGE_THRESHOLD;
            vertical_mode_reg  <= 1'b0;
            page_total_reg     <= 16'd0;
            page_span_reg      <= DEF_PAGE_SPAN;
        end
        else if (cfg_wr)
        begin
            case (cfg_idx)
                REG_DRAG_THRESHOLD: drag_threshold_reg <= pwdata[15:0];
                REG_PAGE_THRESHOLD: page_threshold_reg <= pwdata[15:0];
                REG_VERTICAL_MODE:  vertical_mode_reg  <= pwdata[0];
                REG_PAGE_TOTAL:     page_total_reg     <= pwdata[15:0];
                REG_PAGE_SPAN:      page_span_reg      <= pwdata[15:0];
                default:            ;
            endcase
        end
    end

    // handshakes
    assign out_load      = !out_valid_reg || m_axis_tready;
    assign proc          = in_valid_reg && out_load;
    assign s_axis_tready = !in_valid_reg || out_load;
    assign in_take       = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_take)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (proc)
            begin
                in_valid_reg <= 1'b0;
            end
            if (proc)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_cmd_reg <= cmd_t'(s_axis_tuser);
            in_x_reg   <= s_axis_tdata[15:0];
            in_y_reg   <= s_axis_tdata[31:16];
            in_req_reg <= $signed(s_axis_tdata[48:32]);
        end
        if (proc)
        begin
            out_data_reg <= out_data_next;
        end
    end

    // event logic
    assign dx     = $signed({1'b0, in_x_reg}) - $signed({1'b0, origin_x_reg});
    assign dy     = $signed({1'b0, in_y_reg}) - $signed({1'b0, origin_y_reg});
    assign abs_dx = dx[16] ? 17'(-dx) : 17'(dx);
    assign abs_dy = dy[16] ? 17'(-dy) : 17'(dy);
    assign m_ext  = 18'(drag_amount_reg);
    assign th_ext = $signed({2'b00, page_threshold_reg});
    assign span_ext = (page_span_reg == 16'd0) ? th_ext : $signed({2'b00, page_span_reg});

    always_comb
    begin
        if (m_ext + th_ext <= 18'sd0)
        begin
            target = $signed({2'b00, page_reg}) + 18'sd1;
        end
        else if (m_ext >= th_ext)
        begin
            target = $signed({2'b00, page_reg}) - 18'sd1;
        end
        else
        begin
            target = $signed({2'b00, page_reg});
        end
    end

    always_comb
    begin
        pressed_next     = pressed_reg;
        dragging_next    = dragging_reg;
        origin_x_next    = origin_x_reg;
        origin_y_next    = origin_y_reg;
        drag_amount_next = drag_amount_reg;
        page_next        = page_reg;
        changed          = 1'b0;
        settle_ok        = 1'b0;
        settle           = 18'sd0;
        next_page        = clamp_page(target, page_total_reg);
        case (in_cmd_reg)
            CMD_SET:
            begin
                next_page        = clamp_page(18'(in_req_reg), page_total_reg);
                drag_amount_next = 17'sd0;
                if (next_page != page_reg)
                begin
                    page_next = next_page;
                    changed   = 1'b1;
                end
            end
            CMD_PRESS:
            begin
                if (page_total_reg != 16'd0)
                begin
                    pressed_next     = 1'b1;
                    dragging_next    = 1'b0;
                    origin_x_next    = in_x_reg;
                    origin_y_next    = in_y_reg;
                    drag_amount_next = 17'sd0;
                end
            end
            CMD_MOVE:
            begin
                if (page_total_reg != 16'd0 && pressed_reg)
                begin
                    if (dragging_reg || abs_dx >= {1'b0, drag_threshold_reg}
                        || abs_dy >= {1'b0, drag_threshold_reg})
                    begin
                        dragging_next    = 1'b1;
                        drag_amount_next = vertical_mode_reg ? dy : dx;
                    end
                end
            end
            CMD_RELEASE:
            begin
                if (page_total_reg != 16'd0)
                begin
                    pressed_next  = 1'b0;
                    dragging_next = 1'b0;
                    if (pressed_reg)
                    begin
                        settle = m_ext;
                        if (next_page != page_reg)
                        begin
                            settle    = (next_page > page_reg) ? span_ext + m_ext
                                                               : m_ext - span_ext;
                            page_next = next_page;
                            changed   = 1'b1;
                        end
                        settle_ok        = 1'b1;
                        drag_amount_next = 17'sd0;
                    end
                end
            end
            default:
            begin
            end
        endcase
        out_data_next = {2'b00, settle_ok, settle, dragging_next, drag_amount_next,
                         changed, page_next};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pressed_reg     <= 1'b0;
            dragging_reg    <= 1'b0;
            origin_x_reg    <= 16'd0;
            origin_y_reg    <= 16'd0;
            drag_amount_reg <= 17'sd0;
            page_reg        <= 16'd0;
        end
        else if (proc)
        begin
            pressed_reg     <= pressed_next;
            dragging_reg    <= dragging_next;
            origin_x_reg    <= origin_x_next;
            origin_y_reg    <= origin_y_next;
            drag_amount_reg <= drag_amount_next;
            page_reg        <= page_next;
        end
    end

    // checks
    a_settle_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_data_reg[53] |-> out_data_reg[52:35] == 18'd0)
        else $error("settle start not zero without settle");

    a_drag_needs_press: assert property (@(posedge clk) disable iff (!rst_n)
        dragging_reg |-> pressed_reg)
        else $error("dragging without press");

    a_release_clears: assert property (@(posedge clk) disable iff (!rst_n)
        proc && in_cmd_reg == CMD_RELEASE && page_total_reg != 16'd0 |=> !pressed_reg)
        else $error("release left press state");

    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        proc |=> out_valid_reg && out_data_reg[15:0] == page_reg)
        else $error("result missing or page mismatch");

endmodule
